// ===== src/assert_macros.svh =====
// Assertion macros included by the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cond)) \
      else $error(msg);

`endif

// ===== src/thrq_pkg.sv =====
package thrq_pkg;

   // Fixed field widths of the request and response items.
   localparam int MODE_W      = 3;
   localparam int THREAD_ID_W = 5;
   localparam int COUNT_W     = 6;

   // Number of ids that the thread id field can name.
   localparam int ID_SPAN = 32;

   typedef logic [MODE_W-1:0]      mode_type;
   typedef logic [THREAD_ID_W-1:0] thread_id_type;
   typedef logic [COUNT_W-1:0]     count_type;

   // Request modes.
   localparam mode_type MODE_APPEND = 3'd0;
   localparam mode_type MODE_REMOVE = 3'd1;
   localparam mode_type MODE_POP    = 3'd2;
   localparam mode_type MODE_ROTATE = 3'd3;
   localparam mode_type MODE_FIND   = 3'd4;

   // One response item.
   typedef struct packed {
      thread_id_type result_thread;
      logic          hit;
      logic          error;
      logic          queue_empty;
      count_type     queue_count;
   } rsp_type;

endpackage

// ===== src/thread_ready_queue_list_core.sv =====
// Sequence: an accepted item moves the control state to EXEC; its result is registered
// at the end of EXEC and shown on the rsp_ ports, marked by rsp_strobe. No new item
// is accepted while busy is high; busy is high for the cycle in which the
// link tables, read at the accept edge, are updated from their registered read data.
// Reset: synchronous, active high; clears the membership bits, head, tail, count and
// control state. The link tables are not cleared. The receiver cannot stall.
module thread_ready_queue_list_core #(
   parameter int THREAD_SLOTS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  thrq_pkg::mode_type          req_mode,
   input  thrq_pkg::thread_id_type     req_thread_id,
   output logic                        rsp_strobe,
   output thrq_pkg::thread_id_type     rsp_result_thread,
   output logic                        rsp_hit,
   output logic                        rsp_error,
   output logic                        rsp_queue_empty,
   output thrq_pkg::count_type         rsp_queue_count
);
   import thrq_pkg::*;

`include "assert_macros.svh"

   // Only the ids the request field can name are ever queued.
   localparam int SLOTS = (THREAD_SLOTS < ID_SPAN) ? THREAD_SLOTS : ID_SPAN;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   // Control and queue state.
   logic              state_ff, state_in;
   logic [SLOTS-1:0]  member_ff, member_in;
   idx_type           head_ff, head_in;
   idx_type           tail_ff, tail_in;
   count_type         occ_ff, occ_in;

   // Latched request.
   mode_type          mode_ff;
   thread_id_type     id_ff;

   // Link tables and their registered read data.
   idx_type           next_mem [SLOTS];
   idx_type           prev_mem [SLOTS];
   idx_type           rd_next_ff, rd_prev_ff;
   idx_type           rd_addr;

   // Write ports of the link tables.
   logic              next_we, prev_we;
   idx_type           next_waddr, next_wdata;
   idx_type           prev_waddr, prev_wdata;

   // Response register.
   logic              strobe_ff;
   rsp_type           rsp_ff, rsp_in;

   // Decoded request fields.
   idx_type           idx;
   logic              id_ok;
   logic              is_mem;
   idx_type           target;
   logic              is_head, is_tail;
   logic              do_unlink;

   logic              accept;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_EXEC);

   // Remove reads the links of the named slot; pop and rotate read those of the head.
   assign rd_addr = (req_mode == MODE_REMOVE) ? req_thread_id[IDX_W-1:0] : head_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_next_ff <= next_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
         mode_ff    <= req_mode;
         id_ff      <= req_thread_id;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
   end

   // Decode the latched request against the current queue state.
   assign idx     = id_ff[IDX_W-1:0];
   assign id_ok   = ({1'b0, id_ff} < COUNT_W'(SLOTS));
   assign is_mem  = id_ok && member_ff[idx];
   assign target  = (mode_ff == MODE_REMOVE) ? idx : head_ff;
   assign is_head = (target == head_ff);
   assign is_tail = (target == tail_ff);

   // Execute one request: update head, tail, count, membership and the link tables.
   always_comb begin
      state_in   = state_ff;
      member_in  = member_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      occ_in     = occ_ff;
      next_we    = 1'b0;
      prev_we    = 1'b0;
      next_waddr = tail_ff;
      next_wdata = idx;
      prev_waddr = idx;
      prev_wdata = tail_ff;
      do_unlink  = 1'b0;
      rsp_in     = '0;

      if (state_ff == ST_EXEC) begin
         state_in = ST_IDLE;
         unique case (mode_ff)
            MODE_APPEND: begin
               if (!id_ok || is_mem) begin
                  rsp_in.error = 1'b1;
               end else begin
                  if (occ_ff == '0) begin
                     head_in = idx;
                  end else begin
                     next_we = 1'b1;
                     prev_we = 1'b1;
                  end
                  tail_in          = idx;
                  member_in[idx]   = 1'b1;
                  occ_in           = occ_ff + COUNT_W'(1);
                  rsp_in.hit       = 1'b1;
                  rsp_in.result_thread = id_ff;
               end
            end
            MODE_REMOVE: begin
               if (!is_mem) begin
                  rsp_in.error = 1'b1;
               end else begin
                  do_unlink = 1'b1;
               end
            end
            MODE_POP: begin
               do_unlink = (occ_ff != '0);
            end
            MODE_ROTATE: begin
               if (occ_ff != '0) begin
                  rsp_in.hit           = 1'b1;
                  rsp_in.result_thread = THREAD_ID_W'(head_ff);
               end
               // An empty queue or a single thread stays as it is; with more, the head moves to the tail.
               if (occ_ff > COUNT_W'(1)) begin
                  head_in    = rd_next_ff;
                  tail_in    = head_ff;
                  next_we    = 1'b1;
                  next_waddr = tail_ff;
                  next_wdata = head_ff;
                  prev_we    = 1'b1;
                  prev_waddr = head_ff;
                  prev_wdata = tail_ff;
               end
            end
            MODE_FIND: begin
               if (is_mem) begin
                  rsp_in.hit           = 1'b1;
                  rsp_in.result_thread = id_ff;
               end
            end
            default: begin
            end
         endcase

         // Unlink the target slot from wherever it sits in the list.
         if (do_unlink) begin
            priority if (is_head && is_tail) begin
               head_in = '0;
               tail_in = '0;
            end else if (is_head) begin
               head_in = rd_next_ff;
            end else if (is_tail) begin
               tail_in = rd_prev_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = rd_prev_ff;
               next_wdata = rd_next_ff;
               prev_we    = 1'b1;
               prev_waddr = rd_next_ff;
               prev_wdata = rd_prev_ff;
            end
            member_in[target]    = 1'b0;
            occ_in               = occ_ff - COUNT_W'(1);
            rsp_in.hit           = 1'b1;
            rsp_in.result_thread = THREAD_ID_W'(target);
         end

         rsp_in.queue_count = occ_in;
         rsp_in.queue_empty = (occ_in == '0);
      end else if (accept) begin
         state_in = ST_EXEC;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         member_ff <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         member_ff <= member_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         strobe_ff <= (state_ff == ST_EXEC);
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_result_thread = rsp_ff.result_thread;
   assign rsp_hit           = rsp_ff.hit;
   assign rsp_error         = rsp_ff.error;
   assign rsp_queue_empty   = rsp_ff.queue_empty;
   assign rsp_queue_count   = rsp_ff.queue_count;

   // Checks on the sequencer and the queue bookkeeping.
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted item did not start")
   `ASSERT_NEXT(a_exec_strobe, clock, reset, busy, rsp_strobe, "executed item gave no result")
   `ASSERT_ALWAYS(a_count_members, clock, reset,
      occ_ff == COUNT_W'($countones(member_ff)), "count differs from membership")
   `ASSERT_IMPLY(a_hit_error, clock, reset, rsp_strobe, !(rsp_hit && rsp_error), "hit and error together")
   `ASSERT_IMPLY(a_empty_head, clock, reset, occ_ff == '0,
      head_ff == '0 && tail_ff == '0, "empty queue with stale ends")

endmodule
